// ===== rtl/core/chassis_drag_and_rotational_damping_top_defines.svh =====
// Assertion macros shared by the drag and damping RTL.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef CHASSIS_DRAG_AND_ROTATIONAL_DAMPING_TOP_DEFINES_SVH
`define CHASSIS_DRAG_AND_ROTATIONAL_DAMPING_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define CDRD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdrd assertion failed");

// Check a condition in the cycle after its trigger
`define CDRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdrd assertion failed");

`endif

// ===== rtl/core/cdrd_pkg.sv =====
// Types, latency constants and fixed-point helpers for the drag and damping block.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package cdrd_pkg;

   localparam int SQRT_BITS     = 32;
   localparam int RAD_W         = 2 * SQRT_BITS;
   localparam int DRAG_LAT      = SQRT_BITS + 6;
   localparam int DAMP_CORE_LAT = 8;
   localparam int DAMP_DELAY    = DRAG_LAT - DAMP_CORE_LAT;

   localparam logic [1:0] REG_LINEAR    = 2'd0;
   localparam logic [1:0] REG_QUADRATIC = 2'd1;
   localparam logic [1:0] REG_YAW       = 2'd2;
   localparam logic [1:0] REG_PITCHROLL = 2'd3;

   localparam logic signed [39:0] S32_MAX_W = 40'sd2147483647;
   localparam logic signed [39:0] S32_MIN_W = -40'sd2147483648;

   // index 0 is X
   typedef logic [2:0][31:0] vec_type;
   // entry (i, j) at i*3+j
   typedef logic [8:0][31:0] mat_type;

   typedef struct packed {
      logic [31:0] linear;
      logic [31:0] quadratic;
      logic [31:0] yaw;
      logic [31:0] pitch_roll;
   } coef_type;

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > S32_MAX_W) r = 32'h7FFF_FFFF;
      else if (v < S32_MIN_W) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // magnitude truncated, sign applied, saturated
   function automatic logic [31:0] neg_sat(input logic pos, input logic big,
                                           input logic [49:0] mag);
      logic [49:0] neg;
      logic [31:0] r;
      neg = ~mag + 50'd1;
      if (pos) r = (big || mag > 50'h0_8000_0000) ? 32'h8000_0000 : neg[31:0];
      else r = (big || mag > 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      return r;
   endfunction

   // Q2.30 product, floored
   function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p[63:30];
   endfunction

endpackage

// ===== rtl/core/cdrd_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage, with sideband.
// Depends on cdrd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "chassis_drag_and_rotational_damping_top_defines.svh"

module cdrd_sqrt import cdrd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  vec_type              in_side,
   output logic                 out_valid,
   output logic [SQRT_BITS-1:0] out_root,
   output vec_type              out_side
);

   logic                 vld_ff  [SQRT_BITS];
   logic [RAD_W-1:0]     rem_ff  [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS];
   vec_type              side_ff [SQRT_BITS];

   for (genvar g = 0; g < SQRT_BITS; g++) begin : g_stage
      localparam int B = SQRT_BITS - 1 - g;
      logic                 vld_prev;
      logic [RAD_W-1:0]     rem_prev;
      logic [SQRT_BITS-1:0] root_prev;
      vec_type              side_prev;
      logic [RAD_W+1:0]     trial;
      logic                 take;

      if (g == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = in_rad;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      assign trial = ((RAD_W+2)'(root_prev) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
      assign take  = {2'b00, rem_prev} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= take ? RAD_W'({2'b00, rem_prev} - trial) : rem_prev;
            root_ff[g] <= take ? (root_prev | (SQRT_BITS'(1) << B)) : root_prev;
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_BITS-1];
   assign out_root  = root_ff[SQRT_BITS-1];
   assign out_side  = side_ff[SQRT_BITS-1];

   `CDRD_ASSERT_NEXT(a_hold_on_stall, clock, reset, !en && out_valid, $stable(out_root))
   `CDRD_ASSERT_NOW(a_root_is_floor, clock, reset, out_valid,
      rem_ff[SQRT_BITS-1] <= RAD_W'({out_root, 1'b0}))

endmodule

// ===== rtl/core/cdrd_drag.sv =====
// Drag force pipeline: squared speed, square root, gain and per-axis scaling.
// Depends on cdrd_pkg and cdrd_sqrt.
`timescale 1ns / 1ps

module cdrd_drag import cdrd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  vec_type  in_vel,
   input  coef_type coef,
   output logic     out_valid,
   output vec_type  out_force
);

   logic           vld1_ff, vld2_ff, vld4_ff, vld5_ff, vld6_ff, vld7_ff;
   vec_type        vel1_ff, vel2_ff, vel4_ff, vel5_ff;
   logic [63:0]    sq1_ff [3];
   logic [63:0]    sum2_ff;
   logic           vld3;
   logic [31:0]    root3;
   vec_type        vel3;
   logic [63:0]    prod4_ff;
   logic [48:0]    k5_ff;
   logic [48:0]    hi6_ff [3];
   logic [63:0]    lo6_ff [3];
   logic [2:0]     pos6_ff;
   vec_type        force7_ff;

   cdrd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld2_ff),
      .in_rad    (sum2_ff),
      .in_side   (vel2_ff),
      .out_valid (vld3),
      .out_root  (root3),
      .out_side  (vel3)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld4_ff <= vld3;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq1_ff[i] <= 64'(abs32(in_vel[i])) * 64'(abs32(in_vel[i]));
         end
         vel1_ff  <= in_vel;
         sum2_ff  <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
         vel2_ff  <= vel1_ff;
         prod4_ff <= 64'(coef.quadratic) * 64'(root3);
         vel4_ff  <= vel3;
         k5_ff    <= 49'(coef.linear) + 49'(prod4_ff[63:16]);
         vel5_ff  <= vel4_ff;
         for (int i = 0; i < 3; i++) begin
            hi6_ff[i]  <= 49'(k5_ff[48:32]) * 49'(abs32(vel5_ff[i]));
            lo6_ff[i]  <= 64'(k5_ff[31:0]) * 64'(abs32(vel5_ff[i]));
            pos6_ff[i] <= !vel5_ff[i][31] && (vel5_ff[i] != 32'd0);
         end
         for (int i = 0; i < 3; i++) begin
            force7_ff[i] <= neg_sat(pos6_ff[i], |hi6_ff[i][48:16],
               50'({hi6_ff[i][15:0], 16'd0}) + 50'(lo6_ff[i][63:16]));
         end
      end
   end

   assign out_valid = vld7_ff;
   assign out_force = force7_ff;

endmodule

// ===== rtl/core/cdrd_damp.sv =====
// Damping torque pipeline: rotation matrix, frame changes, scaling and alignment delay.
// Depends on cdrd_pkg.
`timescale 1ns / 1ps

module cdrd_damp import cdrd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  vec_type     in_spin,
   input  logic [31:0] in_qw,
   input  logic [31:0] in_qx,
   input  logic [31:0] in_qy,
   input  logic [31:0] in_qz,
   input  coef_type    coef,
   output vec_type     out_torque
);

   localparam logic signed [39:0] ONE_W = 40'sd1073741824;

   logic signed [33:0] xx1_ff, yy1_ff, zz1_ff, xy1_ff, xz1_ff, yz1_ff;
   logic signed [33:0] wx1_ff, wy1_ff, wz1_ff;
   vec_type            spin1_ff, spin2_ff;
   mat_type            rp_ff [5];
   logic signed [33:0] pw3_ff [9];
   vec_type            wb4_ff;
   logic [63:0]        lo5_ff [3];
   logic [2:0]         pos5_ff;
   vec_type            tb6_ff;
   logic signed [33:0] pt7_ff [9];
   vec_type            tw8_ff;
   vec_type            dly_ff [DAMP_DELAY];

   function automatic logic [31:0] ent_diag(input logic signed [33:0] a,
                                            input logic signed [33:0] b);
      return sat32(ONE_W - ((40'(a) + 40'(b)) <<< 1));
   endfunction

   function automatic logic [31:0] ent_off(input logic signed [33:0] a,
                                           input logic signed [33:0] b,
                                           input logic sub);
      logic signed [39:0] s;
      s = sub ? (40'(a) - 40'(b)) : (40'(a) + 40'(b));
      return sat32(s <<< 1);
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         xx1_ff   <= qmul(in_qx, in_qx);
         yy1_ff   <= qmul(in_qy, in_qy);
         zz1_ff   <= qmul(in_qz, in_qz);
         xy1_ff   <= qmul(in_qx, in_qy);
         xz1_ff   <= qmul(in_qx, in_qz);
         yz1_ff   <= qmul(in_qy, in_qz);
         wx1_ff   <= qmul(in_qw, in_qx);
         wy1_ff   <= qmul(in_qw, in_qy);
         wz1_ff   <= qmul(in_qw, in_qz);
         spin1_ff <= in_spin;

         rp_ff[0][0] <= ent_diag(yy1_ff, zz1_ff);
         rp_ff[0][1] <= ent_off(xy1_ff, wz1_ff, 1'b1);
         rp_ff[0][2] <= ent_off(xz1_ff, wy1_ff, 1'b0);
         rp_ff[0][3] <= ent_off(xy1_ff, wz1_ff, 1'b0);
         rp_ff[0][4] <= ent_diag(xx1_ff, zz1_ff);
         rp_ff[0][5] <= ent_off(yz1_ff, wx1_ff, 1'b1);
         rp_ff[0][6] <= ent_off(xz1_ff, wy1_ff, 1'b1);
         rp_ff[0][7] <= ent_off(yz1_ff, wx1_ff, 1'b0);
         rp_ff[0][8] <= ent_diag(xx1_ff, yy1_ff);
         spin2_ff    <= spin1_ff;
         for (int k = 1; k < 5; k++) begin
            rp_ff[k] <= rp_ff[k-1];
         end

         // into the body frame: transpose
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pw3_ff[i*3+j] <= qmul(rp_ff[0][j*3+i], spin2_ff[j]);
            end
         end
         for (int i = 0; i < 3; i++) begin
            wb4_ff[i] <= sat32(40'(pw3_ff[i*3]) + 40'(pw3_ff[i*3+1]) + 40'(pw3_ff[i*3+2]));
         end
         for (int i = 0; i < 3; i++) begin
            lo5_ff[i]  <= 64'((i == 1) ? coef.yaw : coef.pitch_roll) * 64'(abs32(wb4_ff[i]));
            pos5_ff[i] <= !wb4_ff[i][31] && (wb4_ff[i] != 32'd0);
         end
         for (int i = 0; i < 3; i++) begin
            tb6_ff[i] <= neg_sat(pos5_ff[i], 1'b0, 50'(lo5_ff[i][63:16]));
         end
         // back to the world frame
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pt7_ff[i*3+j] <= qmul(rp_ff[4][i*3+j], tb6_ff[j]);
            end
         end
         for (int i = 0; i < 3; i++) begin
            tw8_ff[i] <= sat32(40'(pt7_ff[i*3]) + 40'(pt7_ff[i*3+1]) + 40'(pt7_ff[i*3+2]));
         end
         dly_ff[0] <= tw8_ff;
         for (int k = 1; k < DAMP_DELAY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign out_torque = dly_ff[DAMP_DELAY-1];

endmodule

// ===== rtl/core/chassis_drag_and_rotational_damping_top.sv =====
// Top level of the drag and damping block: stream ports, register file, two pipelines.
// Depends on cdrd_pkg, cdrd_drag, cdrd_damp and the assertion macro header.
`timescale 1ns / 1ps
`include "chassis_drag_and_rotational_damping_top_defines.svh"

// Accepts one item per clock unless the output stalls; results pass 32 stages of the
// bit-per-stage speed square root plus six arithmetic stages; the torque path is delayed
// to line up with the force path. When a finished result is not taken the whole pipeline
// holds, so req_tready follows rsp_tready whenever a result is waiting. Coefficients are
// read live by the pipeline and are to be written only while it is empty.
module chassis_drag_and_rotational_damping_top import cdrd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vel_x, vel_y, vel_z, spin_x, spin_y, spin_z, quat_w, quat_x, quat_y, quat_z
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z, torque_x, torque_y, torque_z
   output logic [191:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   coef_type coef_ff;
   logic     en;
   logic     wr;
   vec_type  vel, spin, force_v, torque_v;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (wr) begin
         case (csr_paddr[3:2])
            REG_LINEAR:    coef_ff.linear     <= csr_pwdata;
            REG_QUADRATIC: coef_ff.quadratic  <= csr_pwdata;
            REG_YAW:       coef_ff.yaw        <= csr_pwdata;
            REG_PITCHROLL: coef_ff.pitch_roll <= csr_pwdata;
            default:       coef_ff            <= coef_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_LINEAR:    csr_prdata = coef_ff.linear;
         REG_QUADRATIC: csr_prdata = coef_ff.quadratic;
         REG_YAW:       csr_prdata = coef_ff.yaw;
         REG_PITCHROLL: csr_prdata = coef_ff.pitch_roll;
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign vel  = req_tdata[95:0];
   assign spin = req_tdata[191:96];

   cdrd_drag u_drag (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_vel    (vel),
      .coef      (coef_ff),
      .out_valid (rsp_tvalid),
      .out_force (force_v)
   );

   cdrd_damp u_damp (
      .clock      (clock),
      .en         (en),
      .in_spin    (spin),
      .in_qw      (req_tdata[223:192]),
      .in_qx      (req_tdata[255:224]),
      .in_qy      (req_tdata[287:256]),
      .in_qz      (req_tdata[319:288]),
      .coef       (coef_ff),
      .out_torque (torque_v)
   );

   assign rsp_tdata = {torque_v, force_v};

   `CDRD_ASSERT_NOW(a_empty_accepts, clock, reset, !rsp_tvalid, req_tready)

endmodule
